// ===== rtl/core/cbi_pkg.sv =====
// ----------------------------------------------------------------------------
// cbi_pkg
// Shared constants for the clamped barycentric interpolator: fixed port
// widths and the reciprocal used for the mean of three values.
// ----------------------------------------------------------------------------
`default_nettype none

package cbi_pkg;

	localparam int unsigned POINT_W = 63;
	localparam int unsigned VALUE_W = 16;

	// floor(x / 3) == (x * MEAN_RECIP) >> MEAN_SHIFT for every x below 2^18.
	localparam int unsigned MEAN_SHIFT = 19;
	localparam logic [17:0] MEAN_RECIP = 18'd174763;

endpackage

`default_nettype wire

// ===== rtl/core/clamped_barycentric_interp.sv =====
// ----------------------------------------------------------------------------
// clamped_barycentric_interp
// Interpolates one corner attribute over a triangle with barycentric weights
// clamped at zero, falling back to the mean of the corners when the Gram
// determinant is not positive or the clamped weights sum to zero.
// ----------------------------------------------------------------------------
//
//  channel   signals                                         transfer
//  query     start, busy, query_point, corner_a/b/c,         start && !busy
//            value_a/b/c
//  result    done, interpolated_value, degenerate            done (no stall)
//
//  One transaction is accepted in every cycle; busy stays low.
//  The restoring divider resolves one quotient bit per stage and makes up
//  VALUE_BITS of the pipeline stages.
//  Reset clears only the valid chain and the done strobe.
//  The receiver cannot stall, so no stage ever holds.
// ----------------------------------------------------------------------------
`default_nettype none

module clamped_barycentric_interp #(
	parameter int unsigned COORD_BITS = 21,
	parameter int unsigned VALUE_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [cbi_pkg::POINT_W-1:0]     query_point,
	input  wire logic [cbi_pkg::POINT_W-1:0]     corner_a,
	input  wire logic [cbi_pkg::POINT_W-1:0]     corner_b,
	input  wire logic [cbi_pkg::POINT_W-1:0]     corner_c,
	input  wire logic [cbi_pkg::VALUE_W-1:0]     value_a,
	input  wire logic [cbi_pkg::VALUE_W-1:0]     value_b,
	input  wire logic [cbi_pkg::VALUE_W-1:0]     value_c,
	output logic                                 done,
	output logic [cbi_pkg::VALUE_W-1:0]          interpolated_value,
	output logic                                 degenerate
);

	localparam int unsigned C    = COORD_BITS;
	localparam int unsigned V    = VALUE_BITS;
	localparam int unsigned DW   = C + 1;
	localparam int unsigned PW   = 2 * DW;
	localparam int unsigned DOTW = PW + 2;
	localparam int unsigned H    = (DOTW + 1) / 2;
	localparam int unsigned HW   = DOTW - H;
	localparam int unsigned GPW  = 2 * DOTW;
	localparam int unsigned WW   = GPW + 2;
	localparam int unsigned SW   = WW + 2;
	localparam int unsigned NW   = WW + V + 2;
	localparam int unsigned K    = (WW + 31) / 32;
	localparam int unsigned MSW  = V + 2;
	localparam int unsigned MPW  = MSW + 18;
	localparam int unsigned NSTG = V + 10;
	localparam int unsigned LAT  = NSTG + 1;

	logic [NSTG:1] vld_s;
	logic          done_q;
	logic          deg_q;
	logic [V-1:0]  res_q;

	// Stage 1: edge vectors, offset, corner value sum.
	logic signed [DW-1:0] e0_s1 [3];
	logic signed [DW-1:0] e1_s1 [3];
	logic signed [DW-1:0] q_s1  [3];
	logic [V-1:0]         va_s1, vb_s1, vc_s1;
	logic [MSW-1:0]       msum_s1;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e0_s1[i] <= DW'($signed(corner_b[i*C +: C])) - DW'($signed(corner_a[i*C +: C]));
			e1_s1[i] <= DW'($signed(corner_c[i*C +: C])) - DW'($signed(corner_a[i*C +: C]));
			q_s1[i]  <= DW'($signed(query_point[i*C +: C]))
				- DW'($signed(corner_a[i*C +: C]));
		end
		va_s1   <= value_a[V-1:0];
		vb_s1   <= value_b[V-1:0];
		vc_s1   <= value_c[V-1:0];
		msum_s1 <= MSW'(value_a[V-1:0]) + MSW'(value_b[V-1:0]) + MSW'(value_c[V-1:0]);
	end

	// Stage 2: component products and the mean.
	logic signed [PW-1:0] p00_s2 [3];
	logic signed [PW-1:0] p01_s2 [3];
	logic signed [PW-1:0] p11_s2 [3];
	logic signed [PW-1:0] p20_s2 [3];
	logic signed [PW-1:0] p21_s2 [3];
	logic [V-1:0]         va_s2, vb_s2, vc_s2, mean_s2;
	logic [MPW-1:0]       mprod;

	assign mprod = MPW'(msum_s1) * MPW'(cbi_pkg::MEAN_RECIP);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			p00_s2[i] <= e0_s1[i] * e0_s1[i];
			p01_s2[i] <= e0_s1[i] * e1_s1[i];
			p11_s2[i] <= e1_s1[i] * e1_s1[i];
			p20_s2[i] <= q_s1[i] * e0_s1[i];
			p21_s2[i] <= q_s1[i] * e1_s1[i];
		end
		va_s2   <= va_s1;
		vb_s2   <= vb_s1;
		vc_s2   <= vc_s1;
		mean_s2 <= V'(mprod >> cbi_pkg::MEAN_SHIFT);
	end

	// Stage 3: dot products.
	logic signed [DOTW-1:0] d_s3 [5];
	logic [V-1:0]           va_s3, vb_s3, vc_s3, mean_s3;

	always_ff @(posedge clk) begin
		d_s3[0] <= DOTW'(p00_s2[0]) + DOTW'(p00_s2[1]) + DOTW'(p00_s2[2]);
		d_s3[1] <= DOTW'(p01_s2[0]) + DOTW'(p01_s2[1]) + DOTW'(p01_s2[2]);
		d_s3[2] <= DOTW'(p11_s2[0]) + DOTW'(p11_s2[1]) + DOTW'(p11_s2[2]);
		d_s3[3] <= DOTW'(p20_s2[0]) + DOTW'(p20_s2[1]) + DOTW'(p20_s2[2]);
		d_s3[4] <= DOTW'(p21_s2[0]) + DOTW'(p21_s2[1]) + DOTW'(p21_s2[2]);
		va_s3   <= va_s2;
		vb_s3   <= vb_s2;
		vc_s3   <= vc_s2;
		mean_s3 <= mean_s2;
	end

	// Stage 4: partial products of the six Gram terms, split into halves.
	// Pairs: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20.
	logic [DOTW-1:0] opx [6];
	logic [DOTW-1:0] opy [6];

	assign opx[0] = d_s3[0];
	assign opy[0] = d_s3[2];
	assign opx[1] = d_s3[1];
	assign opy[1] = d_s3[1];
	assign opx[2] = d_s3[2];
	assign opy[2] = d_s3[3];
	assign opx[3] = d_s3[1];
	assign opy[3] = d_s3[4];
	assign opx[4] = d_s3[0];
	assign opy[4] = d_s3[4];
	assign opx[5] = d_s3[1];
	assign opy[5] = d_s3[3];

	logic signed [2*HW-1:0]   hh_s4 [6];
	logic signed [HW+H:0]     hl_s4 [6];
	logic signed [HW+H:0]     lh_s4 [6];
	logic [2*H-1:0]           ll_s4 [6];
	logic [V-1:0]             va_s4, vb_s4, vc_s4, mean_s4;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) begin
			hh_s4[k] <= $signed(opx[k][DOTW-1:H]) * $signed(opy[k][DOTW-1:H]);
			hl_s4[k] <= $signed(opx[k][DOTW-1:H]) * $signed({1'b0, opy[k][H-1:0]});
			lh_s4[k] <= $signed({1'b0, opx[k][H-1:0]}) * $signed(opy[k][DOTW-1:H]);
			ll_s4[k] <= opx[k][H-1:0] * opy[k][H-1:0];
		end
		va_s4   <= va_s3;
		vb_s4   <= vb_s3;
		vc_s4   <= vc_s3;
		mean_s4 <= mean_s3;
	end

	// Stage 5: full Gram products.
	logic [GPW-1:0] gp_s5 [6];
	logic [V-1:0]   va_s5, vb_s5, vc_s5, mean_s5;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) begin
			gp_s5[k] <= (GPW'(hh_s4[k]) << (2 * H))
				+ ((GPW'(hl_s4[k]) + GPW'(lh_s4[k])) << H)
				+ GPW'(ll_s4[k]);
		end
		va_s5   <= va_s4;
		vb_s5   <= vb_s4;
		vc_s5   <= vc_s4;
		mean_s5 <= mean_s4;
	end

	// Stage 6: determinant and the two scaled weights.
	logic signed [WW-1:0] den_s6, vn_s6, wn_s6;
	logic [V-1:0]         va_s6, vb_s6, vc_s6, mean_s6;

	always_ff @(posedge clk) begin
		den_s6  <= WW'($signed(gp_s5[0])) - WW'($signed(gp_s5[1]));
		vn_s6   <= WW'($signed(gp_s5[2])) - WW'($signed(gp_s5[3]));
		wn_s6   <= WW'($signed(gp_s5[4])) - WW'($signed(gp_s5[5]));
		va_s6   <= va_s5;
		vb_s6   <= vb_s5;
		vc_s6   <= vc_s5;
		mean_s6 <= mean_s5;
	end

	// Stage 7: third weight and clamping.
	logic signed [WW-1:0] un6;
	logic [WW-1:0]        w_s7 [3];
	logic                 deg_s7;
	logic [V-1:0]         va_s7, vb_s7, vc_s7, mean_s7;

	assign un6 = den_s6 - vn_s6 - wn_s6;

	always_ff @(posedge clk) begin
		w_s7[0] <= un6[WW-1]   ? '0 : un6;
		w_s7[1] <= vn_s6[WW-1] ? '0 : vn_s6;
		w_s7[2] <= wn_s6[WW-1] ? '0 : wn_s6;
		deg_s7  <= den_s6[WW-1] || (den_s6 == '0);
		va_s7   <= va_s6;
		vb_s7   <= vb_s6;
		vc_s7   <= vc_s6;
		mean_s7 <= mean_s6;
	end

	// Stage 8: weight sum and 32-bit slices of weight times value.
	logic [K*32-1:0] wext [3];
	logic [V-1:0]    vsel [3];
	logic [31+V:0]   pp_s8 [3][K];
	logic [SW-1:0]   sum_s8;
	logic            deg_s8;
	logic [V-1:0]    mean_s8;

	assign vsel[0] = va_s7;
	assign vsel[1] = vb_s7;
	assign vsel[2] = vc_s7;

	always_comb begin
		for (int w = 0; w < 3; w++) begin
			wext[w] = (K*32)'(w_s7[w]);
		end
	end

	always_ff @(posedge clk) begin
		for (int w = 0; w < 3; w++) begin
			for (int c = 0; c < K; c++) begin
				pp_s8[w][c] <= (32+V)'(wext[w][c*32 +: 32]) * (32+V)'(vsel[w]);
			end
		end
		sum_s8  <= SW'(w_s7[0]) + SW'(w_s7[1]) + SW'(w_s7[2]);
		deg_s8  <= deg_s7;
		mean_s8 <= mean_s7;
	end

	// Stage 9: one product per weight.
	logic [NW-1:0] wp_s9 [3];
	logic [NW-1:0] wacc [3];
	logic [SW-1:0] sum_s9;
	logic          deg_s9;
	logic [V-1:0]  mean_s9;

	always_comb begin
		for (int w = 0; w < 3; w++) begin
			wacc[w] = '0;
			for (int c = 0; c < K; c++) begin
				wacc[w] = wacc[w] + (NW'(pp_s8[w][c]) << (32 * c));
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int w = 0; w < 3; w++) begin
			wp_s9[w] <= wacc[w];
		end
		sum_s9  <= sum_s8;
		deg_s9  <= deg_s8 || (sum_s8 == '0);
		mean_s9 <= mean_s8;
	end

	// Stage 10 and on: numerator, then one quotient bit per stage.
	logic [NW-1:0] rem_s [V+1];
	logic [SW-1:0] dsum_s [V+1];
	logic [V-1:0]  quo_s [V+1];
	logic          ddeg_s [V+1];
	logic [V-1:0]  dmean_s [V+1];

	always_ff @(posedge clk) begin
		rem_s[0]   <= wp_s9[0] + wp_s9[1] + wp_s9[2];
		dsum_s[0]  <= sum_s9;
		quo_s[0]   <= '0;
		ddeg_s[0]  <= deg_s9;
		dmean_s[0] <= mean_s9;
	end

	for (genvar j = 1; j <= V; j++) begin : g_div
		logic [NW-1:0] trial;
		logic          fits;

		assign trial = NW'(dsum_s[j-1]) << (V - j);
		assign fits  = rem_s[j-1] >= trial;

		always_ff @(posedge clk) begin
			rem_s[j]   <= fits ? rem_s[j-1] - trial : rem_s[j-1];
			quo_s[j]   <= quo_s[j-1] | (fits ? (V'(1) << (V - j)) : '0);
			dsum_s[j]  <= dsum_s[j-1];
			ddeg_s[j]  <= ddeg_s[j-1];
			dmean_s[j] <= dmean_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		res_q <= ddeg_s[V] ? dmean_s[V] : quo_s[V];
		deg_q <= ddeg_s[V];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_s  <= {vld_s[NSTG-1:1], start};
			done_q <= vld_s[NSTG];
		end
	end

	assign busy               = 1'b0;
	assign done               = done_q;
	assign degenerate         = deg_q;
	assign interpolated_value = cbi_pkg::VALUE_W'(res_q);

`ifndef SYNTHESIS
	logic [V-1:0] vmax_in;
	assign vmax_in = (value_a[V-1:0] >= value_b[V-1:0])
		? ((value_a[V-1:0] >= value_c[V-1:0]) ? value_a[V-1:0] : value_c[V-1:0])
		: ((value_b[V-1:0] >= value_c[V-1:0]) ? value_b[V-1:0] : value_c[V-1:0]);

	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(LAT) done)
		else $error("accepted transaction produced no result");

	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without an accepted transaction");

	a_result_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res_q <= $past(vmax_in, LAT)))
		else $error("result above the largest corner value");
`endif

endmodule

`default_nettype wire

// ===== test/clamped_barycentric_interp_test.sv =====
// ----------------------------------------------------------------------------
// clamped_barycentric_interp_test
// Self-checking testbench for the clamped barycentric interpolator. Directed
// triangles cover extreme coordinates and values, degenerate and off-triangle
// cases; random triangles follow. Each transaction is predicted with exact
// wide integer arithmetic and compared with the strobed result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module clamped_barycentric_interp_test;

	localparam int CB = 21;
	localparam int LATENCY = 27;

	typedef struct {
		logic [cbi_pkg::POINT_W-1:0] p, a, b, c;
		logic [cbi_pkg::VALUE_W-1:0] va, vb, vc;
		bit                          drain;
	} query_t;

	typedef struct {
		logic [cbi_pkg::VALUE_W-1:0] value;
		logic                        degen;
	} interp_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [cbi_pkg::POINT_W-1:0] query_point = '0, corner_a = '0, corner_b = '0, corner_c = '0;
	logic [cbi_pkg::VALUE_W-1:0] value_a = '0, value_b = '0, value_c = '0;
	logic done;
	logic [cbi_pkg::VALUE_W-1:0] interpolated_value;
	logic degenerate;

	query_t  pending_queries[$];
	interp_t expected_results[$];
	query_t  driven;
	int      mismatches = 0;
	int      burst_left = 1;
	int      gap_left = 0;
	bit      stimulus_done = 0;

	clamped_barycentric_interp dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.query_point(query_point), .corner_a(corner_a), .corner_b(corner_b),
		.corner_c(corner_c), .value_a(value_a), .value_b(value_b),
		.value_c(value_c), .done(done), .interpolated_value(interpolated_value),
		.degenerate(degenerate)
	);

	always #5 clk = ~clk;

	function automatic longint coord_of(logic [cbi_pkg::POINT_W-1:0] packed_pt, int idx);
		logic signed [CB-1:0] f;
		f = packed_pt[idx*CB +: CB];
		return longint'(f);
	endfunction

	function automatic interp_t interpolate(query_t q);
		longint e0, e1, dq, av;
		longint d00, d01, d11, d20, d21;
		logic signed [127:0] s00, s01, s11, s20, s21, den, un, vn, wn;
		logic [127:0] wsum, num;
		interp_t r;
		d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
		for (int i = 0; i < 3; i++) begin
			av = coord_of(q.a, i);
			e0 = coord_of(q.b, i) - av;
			e1 = coord_of(q.c, i) - av;
			dq = coord_of(q.p, i) - av;
			d00 += e0 * e0; d01 += e0 * e1; d11 += e1 * e1;
			d20 += dq * e0; d21 += dq * e1;
		end
		s00 = d00; s01 = d01; s11 = d11; s20 = d20; s21 = d21;
		den = s00 * s11 - s01 * s01;
		vn = s11 * s20 - s01 * s21;
		wn = s00 * s21 - s01 * s20;
		un = den - vn - wn;
		if (un < 0) un = 0;
		if (vn < 0) vn = 0;
		if (wn < 0) wn = 0;
		wsum = un + vn + wn;
		if (den <= 0 || wsum == 0) begin
			r.value = cbi_pkg::VALUE_W'((32'(q.va) + q.vb + q.vc) / 3);
			r.degen = 1;
		end else begin
			num = un * q.va + vn * q.vb + wn * q.vc;
			r.value = cbi_pkg::VALUE_W'(num / wsum);
			r.degen = 0;
		end
		return r;
	endfunction

	function automatic logic [cbi_pkg::POINT_W-1:0] pack(longint x, longint y, longint z);
		return {CB'(z), CB'(y), CB'(x)};
	endfunction

	function automatic longint rand_coord(int span);
		return longint'($urandom_range(2 * span)) - span;
	endfunction

	function automatic logic [cbi_pkg::POINT_W-1:0] rand_bits();
		return cbi_pkg::POINT_W'({$urandom, $urandom});
	endfunction

	task automatic add_query(logic [cbi_pkg::POINT_W-1:0] p, a, b, c,
			logic [cbi_pkg::VALUE_W-1:0] va, vb, vc);
		query_t q;
		q.p = p; q.a = a; q.b = b; q.c = c;
		q.va = va; q.vb = vb; q.vc = vc; q.drain = 0;
		pending_queries = {pending_queries, q};
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
		end else begin
			if (start && !busy)
				expected_results = {expected_results, interpolate(driven)};
			if (gap_left > 0) begin
				gap_left--;
				start <= 0;
			end else if (pending_queries.size() > 0 &&
					!(pending_queries[0].drain && expected_results.size() > 0)) begin
				driven = pending_queries.pop_front();
				query_point <= driven.p;
				corner_a <= driven.a;
				corner_b <= driven.b;
				corner_c <= driven.c;
				value_a <= driven.va;
				value_b <= driven.vb;
				value_c <= driven.vc;
				start <= 1;
				if (--burst_left == 0) begin
					burst_left = $urandom_range(40, 1);
					gap_left = ($urandom_range(9) < 3) ? 0 : $urandom_range(8, 1);
				end
			end else begin
				start <= 0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: value %h degenerate %b",
						interpolated_value, degenerate);
			end else begin
				interp_t e;
				e = expected_results.pop_front();
				if (e.value !== interpolated_value || e.degen !== degenerate) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected value %h degenerate %b, got %h %b",
							e.value, e.degen, interpolated_value, degenerate);
				end
			end
		end
	end

	initial begin
		longint ax, ay, az, bx, by, bz, k;
		int span;
		logic [cbi_pkg::POINT_W-1:0] pa, pb, pc;
		localparam longint CMAX = (1 <<< (CB - 1)) - 1;
		localparam longint CMIN = -(1 <<< (CB - 1));

		add_query('0, '0, '0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_query('0, '0, '0, '0, 16'h0000, 16'h0001, 16'h0002);
		add_query(pack(300, 300, 0), pack(0, 0, 0), pack(1024, 0, 0),
			pack(0, 1024, 0), 16'h0000, 16'hFFFF, 16'h8000);
		add_query(pack(0, 0, 0), pack(0, 0, 0), pack(1024, 0, 0),
			pack(0, 1024, 0), 16'hFFFF, 16'h0000, 16'h0000);
		add_query(pack(1024, 0, 0), pack(0, 0, 0), pack(1024, 0, 0),
			pack(0, 1024, 0), 16'h1234, 16'hFFFF, 16'h0000);
		add_query(pack(-5000, -5000, 99), pack(0, 0, 0), pack(1024, 0, 0),
			pack(0, 1024, 0), 16'hFFFF, 16'h1111, 16'h2222);
		add_query(pack(CMAX, CMAX, CMAX), pack(0, 0, 0), pack(1, 0, 0),
			pack(0, 1, 0), 16'h7FFF, 16'hFFFF, 16'h0001);
		add_query(pack(CMIN, CMAX, CMIN), pack(CMIN, CMIN, CMIN),
			pack(CMAX, CMIN, CMAX), pack(CMIN, CMAX, CMAX),
			16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_query(pack(CMAX, CMIN, 0), pack(CMAX, CMAX, CMAX),
			pack(CMIN, CMIN, CMIN), pack(CMAX, CMIN, CMIN),
			16'h0000, 16'hFFFF, 16'hABCD);
		add_query(pack(5, 5, 5), pack(0, 0, 0), pack(100, 100, 100),
			pack(300, 300, 300), 16'hFFFF, 16'hFFFE, 16'hFFFD);
		add_query(pack(1, 2, 3), pack(7, 7, 7), pack(7, 7, 7),
			pack(9, 1, 4), 16'h0100, 16'h0200, 16'h0300);
		add_query({cbi_pkg::POINT_W{1'b1}}, {cbi_pkg::POINT_W{1'b1}}, '0,
			{cbi_pkg::POINT_W{1'b1}}, 16'h5555, 16'hAAAA, 16'hFFFF);
		add_query(pack(CMAX, 0, 0), pack(CMIN, 0, 0), pack(CMAX, 0, 0),
			pack(0, CMAX, 0), 16'hFFFF, 16'h0000, 16'hFFFF);

		for (int n = 0; n < 800; n++) begin
			span = ($urandom_range(3) == 0) ? int'(CMAX) : (1 << $urandom_range(16, 2));
			ax = rand_coord(span); ay = rand_coord(span); az = rand_coord(span);
			bx = rand_coord(span); by = rand_coord(span); bz = rand_coord(span);
			pa = pack(ax, ay, az);
			pb = pack(bx, by, bz);
			case ($urandom_range(9))
				0: pc = rand_bits();
				1: pc = pa;
				2: begin
					k = longint'($urandom_range(6)) - 3;
					pc = pack(ax + k * (bx - ax), ay + k * (by - ay), az + k * (bz - az));
				end
				default: pc = pack(rand_coord(span), rand_coord(span), rand_coord(span));
			endcase
			if ($urandom_range(7) == 0) begin
				pa = rand_bits();
				pb = rand_bits();
			end
			add_query(($urandom_range(4) == 0) ? rand_bits()
					: pack(rand_coord(span), rand_coord(span), rand_coord(span)),
				pa, pb, pc, cbi_pkg::VALUE_W'($urandom), cbi_pkg::VALUE_W'($urandom),
				cbi_pkg::VALUE_W'($urandom));
			if (n == 400)
				pending_queries[$].drain = 1;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1;
		wait (pending_queries.size() == 0);
		@(posedge clk);
		while (start || expected_results.size() > 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
